// ----- rtl/linear_probe_hash_table_assert.svh -----
// Assertion macros used by the hash table control module.
// Each macro expects clk and rst_n to be in scope where it is used.
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LPHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define LPHT_NEVER(label, expr, msg) \
    `LPHT_ASSERT(label, !(expr), msg)
`else
`define LPHT_ASSERT(label, prop, msg)
`define LPHT_NEVER(label, expr, msg)
`endif
`endif

// ----- rtl/lpht_pkg.sv -----
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int KEY_BYTES_MAX = 8;
    localparam int KEY_W = 64;
    localparam int VALUE_W = 32;
    localparam int HASH_W = 32;
    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam int HASH_SHIFT = 5;

    localparam logic MODE_GET = 1'b1;

    typedef logic [2:0] res_code_t;

    localparam res_code_t RES_INSERTED = 3'd0;
    localparam res_code_t RES_UPDATED = 3'd1;
    localparam res_code_t RES_FULL = 3'd2;
    localparam res_code_t RES_FOUND = 3'd3;
    localparam res_code_t RES_MISSING = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } row_t;

    typedef struct packed {
        logic      clear_step;
        logic      load;
        logic      hash_step;
        logic      probe_init;
        logic      read;
        logic      advance;
        logic      write;
        logic      finish;
        res_code_t res_code;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic mode_get;
        logic slot_valid;
        logic key_match;
        logic last_probe;
    } sts_t;

    // The key ends at its first zero byte or after key_chars bytes; all later bytes are cleared.
    function automatic logic [KEY_W-1:0] normalize_key(input logic [KEY_W-1:0] raw,
                                                       input int unsigned key_chars);
        logic [KEY_W-1:0] kept;
        logic             alive;
        logic [7:0]       b;
        kept = '0;
        alive = 1'b1;
        for (int i = 0; i < KEY_BYTES_MAX; i++)
        begin
            b = raw[KEY_W-1-8*i -: 8];
            if ((i >= int'(key_chars)) || (b == 8'd0))
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                kept[KEY_W-1-8*i -: 8] = b;
            end
        end
        return kept;
    endfunction

endpackage

// ----- rtl/linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// Open-addressing hash table with linear probing and a djb2 home slot.
// Command channel: a beat (mode, key_bytes, value_in) is taken at a rising edge with start
// high and busy low. Mode 0 inserts or updates, mode 1 looks the key up.
// Result channel: done is high for exactly one cycle with status and value_out; the
// receiver cannot stall, so the result must be taken in that cycle.
// Sequence: the key is hashed one byte per cycle up to its terminating zero; then each
// probe is a registered read of the single-port slot memory followed by a compare. done
// rises in the same cycle that busy falls, so the next beat may be offered alongside
// the result. At most 2**$clog2(TABLE_DEPTH) slots are probed for one item.
// Reset: after rst_n is released the block sweeps the slot memory, one slot per cycle,
// to clear the valid marks; busy stays high throughout.
// A new key offered to a full table is reported as full and dropped.
module linear_probe_hash_table #(
    parameter int TABLE_DEPTH = 2048,
    parameter int KEY_CHARS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [lpht_pkg::KEY_W-1:0]    key_bytes,
    input  logic [lpht_pkg::VALUE_W-1:0]  value_in,
    output logic                          done,
    output logic [2:0]                    status,
    output logic [lpht_pkg::VALUE_W-1:0]  value_out
);

    lpht_pkg::cmd_t cmd;
    lpht_pkg::sts_t sts;

    lpht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd),
        .sts   (sts)
    );

    lpht_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_CHARS   (KEY_CHARS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .key_bytes (key_bytes),
        .value_in  (value_in),
        .status    (status),
        .value_out (value_out)
    );

endmodule

// ----- rtl/lpht_datapath.sv -----
`timescale 1ns / 1ps

module lpht_datapath #(
    parameter int TABLE_DEPTH = 2048,
    parameter int KEY_CHARS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpht_pkg::cmd_t                cmd,
    output lpht_pkg::sts_t                sts,
    input  logic                          mode,
    input  logic [lpht_pkg::KEY_W-1:0]    key_bytes,
    input  logic [lpht_pkg::VALUE_W-1:0]  value_in,
    output lpht_pkg::res_code_t           status,
    output logic [lpht_pkg::VALUE_W-1:0]  value_out
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    lpht_pkg::row_t mem [TABLE_DEPTH];

    logic                           mode_reg;
    logic [lpht_pkg::KEY_W-1:0]     key_reg;
    logic [lpht_pkg::VALUE_W-1:0]   value_reg;
    logic [lpht_pkg::KEY_W-1:0]     shift_reg;
    logic [lpht_pkg::HASH_W-1:0]    hash_reg;
    logic [ADDR_W-1:0]              idx_reg;
    logic [ADDR_W-1:0]              probe_cnt_reg;
    logic [ADDR_W-1:0]              clr_addr_reg;
    lpht_pkg::row_t                 rd_reg;
    lpht_pkg::res_code_t            status_reg;
    logic [lpht_pkg::VALUE_W-1:0]   value_out_reg;

    logic [lpht_pkg::KEY_W-1:0]     norm_key;
    logic                           we;
    logic [ADDR_W-1:0]              waddr;
    lpht_pkg::row_t                 wdata;

    assign norm_key = lpht_pkg::normalize_key(key_bytes, KEY_CHARS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg  <= mode;
            key_reg   <= norm_key;
            value_reg <= value_in;
            shift_reg <= norm_key;
            hash_reg  <= lpht_pkg::HASH_SEED;
        end
        else if (cmd.hash_step)
        begin
            shift_reg <= shift_reg << 8;
            hash_reg  <= (hash_reg << lpht_pkg::HASH_SHIFT) + hash_reg
                         + {24'd0, shift_reg[lpht_pkg::KEY_W-1 -: 8]};
        end
        if (cmd.probe_init)
        begin
            idx_reg       <= hash_reg[ADDR_W-1:0];
            probe_cnt_reg <= '0;
        end
        else if (cmd.advance)
        begin
            idx_reg       <= idx_reg + 1'b1;
            probe_cnt_reg <= probe_cnt_reg + 1'b1;
        end
        if (cmd.finish)
        begin
            status_reg    <= cmd.res_code;
            value_out_reg <= (cmd.res_code == lpht_pkg::RES_FOUND) ? rd_reg.value : '0;
        end
    end

    always_comb
    begin
        we    = cmd.clear_step | cmd.write;
        waddr = cmd.clear_step ? clr_addr_reg : idx_reg;
        if (cmd.clear_step)
        begin
            wdata = '0;
        end
        else
        begin
            wdata.valid = 1'b1;
            wdata.key   = key_reg;
            wdata.value = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.read)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign sts.clear_last = &clr_addr_reg;
    assign sts.hash_done  = (shift_reg[lpht_pkg::KEY_W-1 -: 8] == 8'd0);
    assign sts.mode_get   = (mode_reg == lpht_pkg::MODE_GET);
    assign sts.slot_valid = rd_reg.valid;
    assign sts.key_match  = (rd_reg.key == key_reg);
    assign sts.last_probe = &probe_cnt_reg;

    assign status    = status_reg;
    assign value_out = value_out_reg;

endmodule

// ----- rtl/lpht_ctrl.sv -----
`timescale 1ns / 1ps
`include "linear_probe_hash_table_assert.svh"

module lpht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output lpht_pkg::cmd_t cmd,
    input  lpht_pkg::sts_t sts
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       done_reg;
    logic       done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (sts.hash_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = ST_READ;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!sts.slot_valid)
                begin
                    cmd.finish   = 1'b1;
                    cmd.write    = !sts.mode_get;
                    cmd.res_code = sts.mode_get ? lpht_pkg::RES_MISSING
                                                : lpht_pkg::RES_INSERTED;
                end
                else if (sts.key_match)
                begin
                    cmd.finish   = 1'b1;
                    cmd.write    = !sts.mode_get;
                    cmd.res_code = sts.mode_get ? lpht_pkg::RES_FOUND
                                                : lpht_pkg::RES_UPDATED;
                end
                else if (sts.last_probe)
                begin
                    cmd.finish   = 1'b1;
                    cmd.res_code = sts.mode_get ? lpht_pkg::RES_MISSING
                                                : lpht_pkg::RES_FULL;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = ST_READ;
                end
                if (cmd.finish)
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

    `LPHT_ASSERT(a_done_after_check, done |-> $past(state_reg == ST_CHECK), "result beat without a check")
    `LPHT_ASSERT(a_done_in_idle, done |-> (state_reg == ST_IDLE), "result beat while busy")
    `LPHT_NEVER(a_get_writes, cmd.write && sts.mode_get, "get wrote the table")
    `LPHT_ASSERT(a_start_hashes, (start && !busy) |=> (state_reg == ST_HASH), "accepted beat not hashed")

endmodule
